@@ rtl/dmx_fs_pkg.sv @@
`timescale 1ns / 1ps
// dmx_fs_pkg: shared types and constants of the dmx512 frame serializer
// no dependencies; imported by dmx_fs_front, dmx_fs_back and the top level

package dmx_fs_pkg;

    // stream payload widths
    localparam int SLOT_W     = 8;
    localparam int IN_TDATA_W = 8;
    localparam int IN_TUSER_W = 1;
    localparam int OUT_TDATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BREAK      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAB        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd3;

    // register widths
    localparam int BREAK_W = 5;
    localparam int LEN_W   = 3;
    localparam int CNT_W   = 5;

    // legal ranges and reset values
    localparam logic [BREAK_W-1:0] BREAK_MIN   = 5'd22;
    localparam logic [BREAK_W-1:0] BREAK_MAX   = 5'd30;
    localparam logic [LEN_W-1:0]   LEN_MIN     = 3'd2;
    localparam logic [LEN_W-1:0]   LEN_MAX     = 3'd4;
    localparam logic [BREAK_W-1:0] BREAK_RST   = 5'd22;
    localparam logic [LEN_W-1:0]   MAB_RST     = 3'd2;
    localparam logic [LEN_W-1:0]   STOP_RST    = 3'd4;
    localparam logic [SLOT_W-1:0]  START_CODE_RST = 8'h00;

    // one queued job for the bit sequencer, config already clamped
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [SLOT_W-1:0]  start_code;
        logic               with_header;
        logic [BREAK_W-1:0] break_len;
        logic [LEN_W-1:0]   mab_len;
        logic [LEN_W-1:0]   stop_len;
    } t_cmd;

endpackage

@@ rtl/dmx_fs_front.sv @@
`timescale 1ns / 1ps
// dmx_fs_front: input stream side, config registers and job queue
// depends on dmx_fs_pkg

module dmx_fs_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dmx_fs_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [7:0] slot_value
    input  logic [dmx_fs_pkg::IN_TUSER_W-1:0] s_axis_tuser,  // [0] frame_start
    input  logic                            i_cfg_we,
    input  logic [dmx_fs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmx_fs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_pop,
    output logic                            o_cmd_valid,
    output dmx_fs_pkg::t_cmd                o_cmd
);
    import dmx_fs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [BREAK_W-1:0] r_break;
    logic [LEN_W-1:0]   r_mab;
    logic [LEN_W-1:0]   r_stop;
    logic [SLOT_W-1:0]  r_start_code;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic               push;
    t_cmd               new_cmd;

    function automatic logic [BREAK_W-1:0] clamp_break(input logic [BREAK_W-1:0] v);
        logic [BREAK_W-1:0] r;
        r = v;
        if (v < BREAK_MIN) r = BREAK_MIN;
        if (v > BREAK_MAX) r = BREAK_MAX;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        r = v;
        if (v < LEN_MIN) r = LEN_MIN;
        if (v > LEN_MAX) r = LEN_MAX;
        return r;
    endfunction

    // config register writes, unused bits dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break      <= BREAK_RST;
            r_mab        <= MAB_RST;
            r_stop       <= STOP_RST;
            r_start_code <= START_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BREAK:      r_break      <= i_cfg_data[BREAK_W-1:0];
                CFG_MAB:        r_mab        <= i_cfg_data[LEN_W-1:0];
                CFG_STOP:       r_stop       <= i_cfg_data[LEN_W-1:0];
                CFG_START_CODE: r_start_code <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    // classify the word into a job with clamped lengths
    always_comb begin
        new_cmd.slot        = s_axis_tdata[SLOT_W-1:0];
        new_cmd.start_code  = r_start_code;
        new_cmd.with_header = s_axis_tuser[0];
        new_cmd.break_len   = clamp_break(r_break);
        new_cmd.mab_len     = clamp_len(r_mab);
        new_cmd.stop_len    = clamp_len(r_stop);
    end

    assign s_axis_tready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_count != '0);
    assign o_cmd         = r_mem[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/dmx_fs_back.sv @@
`timescale 1ns / 1ps
// dmx_fs_back: bit sequencer for break, mark after break and slots, with output register
// depends on dmx_fs_pkg

module dmx_fs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  dmx_fs_pkg::t_cmd                 i_cmd,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dmx_fs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [0] line_level
    output logic                             m_axis_tlast     // run_last
);
    import dmx_fs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BREAK = 6'b000010,
        S_MAB   = 6'b000100,
        S_START = 6'b001000,
        S_DATA  = 6'b010000,
        S_STOP  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SLOT_W-1:0]  r_shift, n_shift;
    logic               r_hdr, n_hdr;
    logic               r_out_valid;
    logic               r_level;
    logic               r_last;

    logic               adv;
    logic               emit;
    logic               lvl;
    logic               lst;

    assign adv   = !r_out_valid || m_axis_tready;
    assign o_pop = i_cmd_valid && (r_state == S_IDLE);

    // next state and the bit of this cycle
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_hdr   = r_hdr;
        emit    = 1'b0;
        lvl     = 1'b0;
        lst     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.with_header) begin
                        n_state = S_BREAK;
                        n_cnt   = i_cmd.break_len - 5'd1;
                        n_shift = i_cmd.start_code;
                        n_hdr   = 1'b1;
                    end else begin
                        n_state = S_START;
                        n_shift = i_cmd.slot;
                        n_hdr   = 1'b0;
                    end
                end
            end
            S_BREAK: begin
                if (adv) begin
                    emit = 1'b1;
                    lvl  = 1'b0;
                    if (r_cnt == '0) begin
                        n_state = S_MAB;
                        n_cnt   = {{(CNT_W-LEN_W){1'b0}}, r_cmd.mab_len} - 5'd1;
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
            end
            S_MAB: begin
                if (adv) begin
                    emit = 1'b1;
                    lvl  = 1'b1;
                    if (r_cnt == '0) begin
                        n_state = S_START;
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
            end
            S_START: begin
                if (adv) begin
                    emit    = 1'b1;
                    lvl     = 1'b0;
                    n_state = S_DATA;
                    n_cnt   = CNT_W'(SLOT_W - 1);
                end
            end
            S_DATA: begin
                if (adv) begin
                    emit    = 1'b1;
                    lvl     = r_shift[0];
                    n_shift = {1'b0, r_shift[SLOT_W-1:1]};
                    if (r_cnt == '0) begin
                        n_state = S_STOP;
                        n_cnt   = {{(CNT_W-LEN_W){1'b0}}, r_cmd.stop_len} - 5'd1;
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
            end
            S_STOP: begin
                if (adv) begin
                    emit = 1'b1;
                    lvl  = 1'b1;
                    lst  = (r_cnt == '0) && !r_hdr;
                    if (r_cnt == '0) begin
                        if (r_hdr) begin
                            // start code done, the data slot follows
                            n_state = S_START;
                            n_shift = r_cmd.slot;
                            n_hdr   = 1'b0;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_cnt = r_cnt - 5'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hdr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hdr   <= n_hdr;
        end
    end

    // sequencer working registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_cnt   <= n_cnt;
        r_shift <= n_shift;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_level <= lvl;
            r_last  <= lst;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, r_level};
    assign m_axis_tlast  = r_last;

endmodule

@@ rtl/dmx512_frame_serializer_top.sv @@
`timescale 1ns / 1ps
// dmx512_frame_serializer_top: slot byte in, one line-level word per bit time out
// depends on dmx_fs_pkg, dmx_fs_front, dmx_fs_back
//
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid / tready  | tdata[7:0] slot_value, tuser[0] frame_start
// m_axis    | out | m_axis_tvalid / tready  | tdata[0] line_level, tlast run_last
// cfg       | in  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// one slot item is a start bit, eight data bits and its stop bits; with frame_start it is
// led by a break, a mark after break and the start code slot. the back sequencer loads
// each queued job while idle, then emits one bit word per cycle unless m_axis stalls.
// reset is synchronous, active low; it empties the queue, idles the sequencer and
// restores the register defaults. a stall on m_axis holds the output register and
// the sequencer; s_axis keeps taking words while the queue has room.

module dmx512_frame_serializer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dmx_fs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] slot_value
    input  logic [dmx_fs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // [0] frame_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dmx_fs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [0] line_level, [7:1] zero
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [dmx_fs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmx_fs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dmx_fs_pkg::*;

    logic cmd_valid;
    logic pop;
    t_cmd cmd;

    // front: config, classify, queue
    dmx_fs_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pop         (pop),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    // back: bit sequencer and output register
    dmx_fs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/dmx_fs_checker.sv @@
`timescale 1ns / 1ps
// dmx_fs_props: port-level checks on the serializer output stream
// depends on dmx_fs_pkg; bound to dmx512_frame_serializer_top

module dmx_fs_props (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dmx_fs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // nothing is shown right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // the last word of an item is a stop bit, so the line is high
    a_last_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0])
        else $error("last word of an item is not high");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[dmx_fs_pkg::OUT_TDATA_W-1:1] == '0))
        else $error("nonzero padding in output word");

endmodule

bind dmx512_frame_serializer_top dmx_fs_props u_dmx_fs_props (.*);

@@ test/dmx_fs_checker.sv @@
`timescale 1ns / 1ps
// dmx_fs_checker: watches the slot, line and config channels of the dmx512 serializer,
// predicts every line word from the accepted slots and compares them in order
// depends on dmx_fs_pkg

module dmx_fs_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [dmx_fs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] slot_value
    input  logic [dmx_fs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // [0] frame_start
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [dmx_fs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [0] line_level, [7:1] zero
    input  logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [dmx_fs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmx_fs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import dmx_fs_pkg::*;

    typedef struct packed {
        logic level;
        logic last;
    } t_line_bit;

    // expected line words, oldest first
    t_line_bit line_bits_q[$];
    t_line_bit want_bit;

    // shadow copy of the registers, stored raw and limited when used
    logic [BREAK_W-1:0] break_len;
    logic [LEN_W-1:0]   mab_len;
    logic [LEN_W-1:0]   stop_len;
    logic [SLOT_W-1:0]  start_code;
    int                 fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    function automatic int unsigned limit_len(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic push_run(logic level, int unsigned count);
        t_line_bit w;
        w.level = level;
        w.last  = 1'b0;
        repeat (count) line_bits_q.push_back(w);
    endtask

    // start bit, eight data bits lsb first, stop bits
    task automatic push_slot_bits(logic [SLOT_W-1:0] value);
        push_run(1'b0, 1);
        for (int b = 0; b < SLOT_W; b++) push_run(value[b], 1);
        push_run(1'b1, limit_len(stop_len, LEN_MIN, LEN_MAX));
    endtask

    // all line words caused by one slot word, the last one marked
    task automatic predict_slot_bits(logic [SLOT_W-1:0] value, logic frame_start);
        t_line_bit tail;
        if (frame_start) begin
            push_run(1'b0, limit_len(break_len, BREAK_MIN, BREAK_MAX));
            push_run(1'b1, limit_len(mab_len, LEN_MIN, LEN_MAX));
            push_slot_bits(start_code);
        end
        push_slot_bits(value);
        tail = line_bits_q.pop_back();
        tail.last = 1'b1;
        line_bits_q.push_back(tail);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            break_len  = BREAK_RST;
            mab_len    = MAB_RST;
            stop_len   = STOP_RST;
            start_code = START_CODE_RST;
            line_bits_q.delete();
        end else begin
            // compare each accepted line word with the oldest expectation
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                if (line_bits_q.size() == 0) begin
                    $error("unexpected line word: line_level %0b run_last %0b",
                           m_axis_tdata[0], m_axis_tlast);
                    fail_cnt++;
                end else begin
                    want_bit = line_bits_q.pop_front();
                    if (m_axis_tdata[0] !== want_bit.level) begin
                        $error("line_level: expected %0b, got %0b",
                               want_bit.level, m_axis_tdata[0]);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want_bit.last) begin
                        $error("run_last: expected %0b, got %0b",
                               want_bit.last, m_axis_tlast);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1:1] !== '0) begin
                        $error("tdata padding: expected 0, got %0h",
                               m_axis_tdata[OUT_TDATA_W-1:1]);
                        fail_cnt++;
                    end
                end
            end
            // predict from each accepted slot word
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                predict_slot_bits(s_axis_tdata[SLOT_W-1:0], s_axis_tuser[0]);
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BREAK:      break_len  = i_cfg_data[BREAK_W-1:0];
                    CFG_MAB:        mab_len    = i_cfg_data[LEN_W-1:0];
                    CFG_STOP:       stop_len   = i_cfg_data[LEN_W-1:0];
                    CFG_START_CODE: start_code = i_cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= line_bits_q.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: stimulus and verdict for dmx512_frame_serializer_top, random idling on both streams
// depends on dmx_fs_pkg, dmx512_frame_serializer_top, dmx_fs_checker

module tb;
    import dmx_fs_pkg::*;

    localparam int CYCLE_LIMIT   = 900000;
    localparam int PHASE_ITEMS   = 42;
    localparam int RANDOM_PHASES = 6;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] slot_value
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // [0] frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] line_level, [7:1] zero
    logic                   m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    int fail_count;
    int pending_bits;
    int cycle_cnt = 0;
    int send_mode = 0;
    int recv_mode = 0;

    dmx512_frame_serializer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    dmx_fs_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_bits)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // mode 0 never idles, otherwise a random idle gap before each word
    function automatic int pick_gap(int mode);
        if (mode == 0) return 0;
        return $urandom_range(0, 9);
    endfunction

    // line side: stall a random number of cycles before each word
    initial begin
        int gap;
        forever begin
            gap = pick_gap(recv_mode);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if ($urandom_range(0, 31) == 0) recv_mode = (recv_mode == 0) ? 1 : 0;
        end
    end

    // offer one slot word and hold it until taken
    task automatic send_slot(logic [SLOT_W-1:0] value, logic frame_start);
        int gap;
        gap = pick_gap(send_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= value;
        s_axis_tuser[0] <= frame_start;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // stop sending and wait until every predicted line word has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_bits != 0);
    endtask

    // write all four registers on consecutive cycles, block idle
    task automatic set_config(logic [CFG_DATA_W-1:0] brk, logic [CFG_DATA_W-1:0] mab,
                              logic [CFG_DATA_W-1:0] stop, logic [CFG_DATA_W-1:0] code);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BREAK;
        i_cfg_data  <= brk;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAB;
        i_cfg_data  <= mab;
        @(posedge i_clk);
        i_cfg_index <= CFG_STOP;
        i_cfg_data  <= stop;
        @(posedge i_clk);
        i_cfg_index <= CFG_START_CODE;
        i_cfg_data  <= code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // half the time a legal value, otherwise any byte so the limits get hit
    function automatic logic [CFG_DATA_W-1:0] pick_len(int lo, int hi);
        if ($urandom_range(0, 1)) return CFG_DATA_W'($urandom_range(lo, hi));
        return CFG_DATA_W'($urandom_range(0, 255));
    endfunction

    // frames of 1 to 12 slots with random bytes, some framing flags flipped
    task automatic run_random_frames(int n_items);
        int sent;
        int frame_left;
        int pause_at;
        logic fs;
        sent       = 0;
        frame_left = 0;
        pause_at   = $urandom_range(n_items / 4, 3 * n_items / 4);
        while (sent < n_items) begin
            if (sent == pause_at) wait_drained();
            if (frame_left == 0) begin
                fs         = 1'b1;
                frame_left = $urandom_range(1, 12);
                send_mode  = $urandom_range(0, 2);
            end else begin
                fs = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) fs = ~fs;
            frame_left--;
            send_slot(SLOT_W'($urandom_range(0, 255)), fs);
            sent++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, data extremes and alternating patterns
        send_slot(8'h00, 1'b1);
        send_slot(8'hFF, 1'b0);
        send_slot(8'hA5, 1'b0);
        send_slot(8'h5A, 1'b0);
        send_slot(8'h01, 1'b0);
        send_slot(8'h80, 1'b0);
        send_slot(8'hFF, 1'b1);
        wait_drained();

        // longest break and mark, start code ff, shortest stop
        set_config(8'd30, 8'd4, 8'd2, 8'hFF);
        send_slot(8'h00, 1'b1);
        send_slot(8'h55, 1'b0);
        send_slot(8'hAA, 1'b0);
        send_slot(8'hFF, 1'b1);
        wait_drained();

        // zero values, raised to the lower limits
        set_config(8'd0, 8'd0, 8'd0, 8'hAA);
        send_slot(8'h3C, 1'b1);
        send_slot(8'hC3, 1'b0);
        wait_drained();

        // all ones in the length registers, lowered to the upper limits
        set_config(8'hFF, 8'hFF, 8'hFF, 8'h55);
        send_slot(8'h0F, 1'b1);
        send_slot(8'hF0, 1'b0);
        wait_drained();

        // just below the limits
        set_config(8'd21, 8'd1, 8'd1, 8'h01);
        send_slot(8'h80, 1'b1);
        send_slot(8'h7E, 1'b0);
        wait_drained();

        // random register settings, one per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(pick_len(BREAK_MIN, BREAK_MAX), pick_len(LEN_MIN, LEN_MAX),
                       pick_len(LEN_MIN, LEN_MAX), CFG_DATA_W'($urandom_range(0, 255)));
            run_random_frames(PHASE_ITEMS);
            wait_drained();
        end

        // let any stray word show up
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
